// ===== rtl/core/pld_pkg.sv =====
package pld_pkg;

    localparam int POS_W  = 24;
    localparam int DIAM_W = 16;
    localparam int LEN_W  = 40;
    localparam int WSUM_W = 64;
    localparam int DSQ_W  = 32;
    localparam int ABS_W  = POS_W + 1;
    localparam int S2_W   = 50;
    localparam int MUL_W  = ABS_W + DSQ_W;
    localparam int ROOT_W = 32;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = 6;

    // square root and divide steps: one result bit per step
    localparam int SEG_STEPS  = 25;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 64;

    localparam logic [DIAM_W-1:0] MIN_DIAM_RST = 16'd1;
    localparam logic [DIAM_W-1:0] MAX_DIAM_RST = 16'd25600;

    localparam logic CFG_MIN_DIAMETER = 1'b0;
    localparam logic CFG_MAX_DIAMETER = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DIAM = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;
    localparam logic [1:0] STATUS_SAT      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_SQD,
        S_DSQ,
        S_SEG_START,
        S_SEG_RUN,
        S_PROD,
        S_ACC,
        S_UPDATE,
        S_DIV_START,
        S_DIV_RUN,
        S_ROOT_START,
        S_ROOT_RUN,
        S_FINISH
    } pld_state_t;

    typedef enum logic [2:0] {
        MUL_DX,
        MUL_DY,
        MUL_DZ,
        MUL_DIAM,
        MUL_SEG
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     dsq_load;
        logic     seg_load;
        logic     root_load;
        logic     sqrt_step;
        logic     prod_acc;
        logic     update;
        logic     div_load;
        logic     div_step;
        logic     out_load;
    } pld_cmd_t;

    typedef struct packed {
        logic in_vessel;
        logic last;
        logic cnt_zero;
        logic need_div;
    } pld_stat_t;

    function automatic logic [ABS_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        logic [ABS_W-1:0] d;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        return d[ABS_W-1] ? (~d + 1'b1) : d;
    endfunction

endpackage

// ===== rtl/core/pld_ctrl.sv =====
module pld_ctrl
    import pld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  pld_stat_t stat,
    output pld_cmd_t  cmd
);

    pld_state_t state_reg;
    pld_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DX;
        in_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = stat.in_vessel ? S_SQX : S_SQD;
                end
            end
            S_SQX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DY;
                cmd.acc_load = 1'b1;
                state_next   = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DZ;
                cmd.acc_add = 1'b1;
                state_next  = S_SQD;
            end
            S_SQD:
            begin
                // inside a vessel this also folds dz squared into the sum
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIAM;
                cmd.acc_add = stat.in_vessel;
                state_next  = stat.in_vessel ? S_SEG_START : S_DSQ;
            end
            S_DSQ:
            begin
                cmd.dsq_load = 1'b1;
                state_next   = S_UPDATE;
            end
            S_SEG_START:
            begin
                cmd.dsq_load = 1'b1;
                cmd.seg_load = 1'b1;
                state_next   = S_SEG_RUN;
            end
            S_SEG_RUN:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEG;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.prod_acc = 1'b1;
                state_next   = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (!stat.last)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.need_div)
                begin
                    state_next = S_DIV_START;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV_START:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_ROOT_START;
                end
            end
            S_ROOT_START:
            begin
                cmd.root_load = 1'b1;
                state_next    = S_ROOT_RUN;
            end
            S_ROOT_RUN:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/pld_dp.sv =====
module pld_dp
    import pld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [DIAM_W-1:0]        cfg_data,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic [DIAM_W-1:0]        point_diameter,
    input  logic                     last_point,
    input  pld_cmd_t                 cmd,
    output pld_stat_t                stat,
    output logic [LEN_W-1:0]         total_length,
    output logic [DIAM_W-1:0]        mean_diameter,
    output logic [1:0]               status,
    output logic                     zero_segment_seen
);

    // configuration and per-vessel state
    logic [DIAM_W-1:0] min_diam_reg, min_diam_next;
    logic [DIAM_W-1:0] max_diam_reg, max_diam_next;
    logic [POS_W-1:0]  prev_x_reg, prev_x_next;
    logic [POS_W-1:0]  prev_y_reg, prev_y_next;
    logic [POS_W-1:0]  prev_z_reg, prev_z_next;
    logic [DSQ_W-1:0]  prev_dsq_reg, prev_dsq_next;
    logic              inside_reg, inside_next;
    logic [LEN_W-1:0]  len_sum_reg, len_sum_next;
    logic [WSUM_W-1:0] w_sum_reg, w_sum_next;
    logic              bad_reg, bad_next;
    logic              coin_reg, coin_next;
    logic              ovf_reg, ovf_next;

    // working registers
    logic [POS_W-1:0]  cur_x_reg, cur_x_next;
    logic [POS_W-1:0]  cur_y_reg, cur_y_next;
    logic [POS_W-1:0]  cur_z_reg, cur_z_next;
    logic [DIAM_W-1:0] cur_d_reg, cur_d_next;
    logic              last_reg, last_next;
    logic [ABS_W-1:0]  adx_reg, adx_next;
    logic [ABS_W-1:0]  ady_reg, ady_next;
    logic [ABS_W-1:0]  adz_reg, adz_next;
    logic [MUL_W-1:0]  mul_reg, mul_next;
    logic [S2_W-1:0]   acc_reg, acc_next;
    logic [DSQ_W-1:0]  dsq_reg, dsq_next;
    logic [WSUM_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [WSUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0]  drem_reg, drem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [DIAM_W-1:0] out_md_reg, out_md_next;
    logic [1:0]        out_st_reg, out_st_next;
    logic              out_zs_reg, out_zs_next;

    logic [ABS_W-1:0]  mul_a;
    logic [DSQ_W-1:0]  mul_b;
    logic [DSQ_W:0]    dsq_pair;
    logic [REM_W+1:0]  sq_shift;
    logic [REM_W+1:0]  sq_trial;
    logic [LEN_W:0]    dv_shift;
    logic [LEN_W:0]    dv_div;
    logic [LEN_W:0]    len_add;
    logic [WSUM_W:0]   w_add;
    logic [1:0]        st_code;
    logic              need_div;

    always_comb
    begin
        dsq_pair = {1'b0, prev_dsq_reg} + {1'b0, dsq_reg};
        case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = adx_reg;
                mul_b = DSQ_W'(adx_reg);
            end
            MUL_DY:
            begin
                mul_a = ady_reg;
                mul_b = DSQ_W'(ady_reg);
            end
            MUL_DZ:
            begin
                mul_a = adz_reg;
                mul_b = DSQ_W'(adz_reg);
            end
            MUL_DIAM:
            begin
                mul_a = ABS_W'(cur_d_reg);
                mul_b = DSQ_W'(cur_d_reg);
            end
            MUL_SEG:
            begin
                // segment length times floored mean of squared diameters
                mul_a = root_reg[ABS_W-1:0];
                mul_b = dsq_pair[DSQ_W:1];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_shift = {rem_reg, rad_reg[WSUM_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign dv_shift = {drem_reg, quo_reg[WSUM_W-1]};
    assign dv_div   = {1'b0, len_sum_reg};
    assign len_add  = {1'b0, len_sum_reg} + (LEN_W + 1)'(root_reg[ABS_W-1:0]);
    assign w_add    = {1'b0, w_sum_reg} + (WSUM_W + 1)'(mul_reg);
    assign need_div = !bad_reg && !ovf_reg && (len_sum_reg != '0);

    always_comb
    begin
        if (bad_reg)
        begin
            st_code = STATUS_BAD_DIAM;
        end
        else if (ovf_reg)
        begin
            st_code = STATUS_SAT;
        end
        else if (len_sum_reg == '0)
        begin
            st_code = STATUS_ZERO_LEN;
        end
        else
        begin
            st_code = STATUS_OK;
        end
    end

    always_comb
    begin
        min_diam_next = min_diam_reg;
        max_diam_next = max_diam_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        prev_z_next   = prev_z_reg;
        prev_dsq_next = prev_dsq_reg;
        inside_next   = inside_reg;
        len_sum_next  = len_sum_reg;
        w_sum_next    = w_sum_reg;
        bad_next      = bad_reg;
        coin_next     = coin_reg;
        ovf_next      = ovf_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cur_z_next    = cur_z_reg;
        cur_d_next    = cur_d_reg;
        last_next     = last_reg;
        adx_next      = adx_reg;
        ady_next      = ady_reg;
        adz_next      = adz_reg;
        mul_next      = mul_reg;
        acc_next      = acc_reg;
        dsq_next      = dsq_reg;
        rad_next      = rad_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        quo_next      = quo_reg;
        drem_next     = drem_reg;
        cnt_next      = cnt_reg;
        out_len_next  = out_len_reg;
        out_md_next   = out_md_reg;
        out_st_next   = out_st_reg;
        out_zs_next   = out_zs_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_DIAMETER: min_diam_next = cfg_data;
                CFG_MAX_DIAMETER: max_diam_next = cfg_data;
                default:          min_diam_next = min_diam_reg;
            endcase
        end

        if (cmd.load_in)
        begin
            cur_x_next = pos_x;
            cur_y_next = pos_y;
            cur_z_next = pos_z;
            cur_d_next = point_diameter;
            last_next  = last_point;
            adx_next   = abs_diff(prev_x_reg, pos_x);
            ady_next   = abs_diff(prev_y_reg, pos_y);
            adz_next   = abs_diff(prev_z_reg, pos_z);
            if (point_diameter < min_diam_reg || point_diameter > max_diam_reg)
            begin
                bad_next = 1'b1;
            end
        end

        if (cmd.mul_en)
        begin
            mul_next = MUL_W'(mul_a) * MUL_W'(mul_b);
        end

        if (cmd.acc_load)
        begin
            acc_next = S2_W'(mul_reg);
        end
        else if (cmd.acc_add)
        begin
            acc_next = acc_reg + S2_W'(mul_reg);
        end

        if (cmd.dsq_load)
        begin
            dsq_next = mul_reg[DSQ_W-1:0];
        end

        // radicand left aligned so pairs of bits come off the top
        if (cmd.seg_load)
        begin
            rad_next  = {acc_reg, (WSUM_W - S2_W)'(0)};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(SEG_STEPS - 1);
        end
        else if (cmd.root_load)
        begin
            rad_next  = quo_reg;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_STEPS - 1);
        end
        else if (cmd.sqrt_step)
        begin
            rad_next = {rad_reg[WSUM_W-3:0], 2'b00};
            if (sq_shift >= sq_trial)
            begin
                rem_next  = REM_W'(sq_shift - sq_trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = sq_shift[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.div_load)
        begin
            quo_next  = w_sum_reg;
            drem_next = '0;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
        end
        else if (cmd.div_step)
        begin
            if (dv_shift >= dv_div)
            begin
                drem_next = LEN_W'(dv_shift - dv_div);
                quo_next  = {quo_reg[WSUM_W-2:0], 1'b1};
            end
            else
            begin
                drem_next = dv_shift[LEN_W-1:0];
                quo_next  = {quo_reg[WSUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.prod_acc)
        begin
            if (acc_reg == '0)
            begin
                coin_next = 1'b1;
            end
            if (len_add[LEN_W])
            begin
                len_sum_next = '1;
                ovf_next     = 1'b1;
            end
            else
            begin
                len_sum_next = len_add[LEN_W-1:0];
            end
            if (w_add[WSUM_W])
            begin
                w_sum_next = '1;
                ovf_next   = 1'b1;
            end
            else
            begin
                w_sum_next = w_add[WSUM_W-1:0];
            end
        end

        if (cmd.update)
        begin
            prev_x_next   = cur_x_reg;
            prev_y_next   = cur_y_reg;
            prev_z_next   = cur_z_reg;
            prev_dsq_next = dsq_reg;
            inside_next   = 1'b1;
        end

        if (cmd.out_load)
        begin
            out_len_next = len_sum_reg;
            out_st_next  = st_code;
            out_zs_next  = coin_reg;
            if (st_code != STATUS_OK)
            begin
                out_md_next = '0;
            end
            else if (root_reg[ROOT_W-1:DIAM_W] != '0)
            begin
                out_md_next = '1;
            end
            else
            begin
                out_md_next = root_reg[DIAM_W-1:0];
            end
            prev_x_next   = '0;
            prev_y_next   = '0;
            prev_z_next   = '0;
            prev_dsq_next = '0;
            inside_next   = 1'b0;
            len_sum_next  = '0;
            w_sum_next    = '0;
            bad_next      = 1'b0;
            coin_next     = 1'b0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_diam_reg <= MIN_DIAM_RST;
            max_diam_reg <= MAX_DIAM_RST;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
            prev_dsq_reg <= '0;
            inside_reg   <= 1'b0;
            len_sum_reg  <= '0;
            w_sum_reg    <= '0;
            bad_reg      <= 1'b0;
            coin_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            min_diam_reg <= min_diam_next;
            max_diam_reg <= max_diam_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            prev_z_reg   <= prev_z_next;
            prev_dsq_reg <= prev_dsq_next;
            inside_reg   <= inside_next;
            len_sum_reg  <= len_sum_next;
            w_sum_reg    <= w_sum_next;
            bad_reg      <= bad_next;
            coin_reg     <= coin_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        cur_z_reg   <= cur_z_next;
        cur_d_reg   <= cur_d_next;
        last_reg    <= last_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        adz_reg     <= adz_next;
        mul_reg     <= mul_next;
        acc_reg     <= acc_next;
        dsq_reg     <= dsq_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        quo_reg     <= quo_next;
        drem_reg    <= drem_next;
        cnt_reg     <= cnt_next;
        out_len_reg <= out_len_next;
        out_md_reg  <= out_md_next;
        out_st_reg  <= out_st_next;
        out_zs_reg  <= out_zs_next;
    end

    assign stat.in_vessel = inside_reg;
    assign stat.last      = last_reg;
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.need_div  = need_div;

    assign total_length      = out_len_reg;
    assign mean_diameter     = out_md_reg;
    assign status            = out_st_reg;
    assign zero_segment_seen = out_zs_reg;

endmodule

// ===== rtl/core/polyline_length_mean_diameter.sv =====
// Vessel polyline length and volume-equivalent mean diameter. Points arrive one per
// transfer; the last_point flag closes the vessel and produces one result transfer
// with the saturating total length, floor(sqrt(floor(W / L))) as mean diameter,
// a status code and the coincident-point flag. A point that continues a vessel
// squares dx, dy, dz and its diameter on one shared 25x32 multiplier, then runs a
// 25-step bit-serial square root for the segment length, then forms the weighted
// product on the same multiplier and accumulates it. The first point of a vessel only
// squares its diameter. Closing a vessel with status ok adds a 64-step restoring
// divide and a 32-step square root before the result is registered. The result
// waits in an output register, so the next point is taken while it is held; only a
// following end of vessel waits for the register to be free.
module polyline_length_mean_diameter
    import pld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [DIAM_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic [DIAM_W-1:0]        point_diameter,
    input  logic                     last_point,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LEN_W-1:0]         total_length,
    output logic [DIAM_W-1:0]        mean_diameter,
    output logic [1:0]               status,
    output logic                     zero_segment_seen
);

    pld_cmd_t  cmd;
    pld_stat_t stat;

    pld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pld_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .pos_z             (pos_z),
        .point_diameter    (point_diameter),
        .last_point        (last_point),
        .cmd               (cmd),
        .stat              (stat),
        .total_length      (total_length),
        .mean_diameter     (mean_diameter),
        .status            (status),
        .zero_segment_seen (zero_segment_seen)
    );

endmodule
